@@ src/lfu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants for the LFU cache table.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;
    localparam int COUNT_BITS_DEF = 16;
    localparam int STAMP_BITS     = 32;
    localparam int CAP_BITS       = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // update command broadcast to the cell row at the end of a scan
    typedef struct packed {
        logic touch;      // hit entry: count up, new stamp
        logic write_val;  // hit entry: replace value
        logic evict;      // drop the victim entry
        logic insert;     // fill a slot with the new key
    } cmd_t;

endpackage

@@ src/lfu_cache_table_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cache_table_core
// LFU key/value cache built as a row of entry cells with a walking token.
// ----------------------------------------------------------------------------
// From acceptance to result, an operation goes as follows: a search token
// walks the cell row one cell per cycle, collecting the key match, the entry
// count, the least used oldest entry and the first free slot; then the DONE
// state applies the update and loads the result register once that register
// is free. One operation is in flight at a time; the next beat is taken as
// soon as the update is done, even while the previous result waits.
module lfu_cache_table_core #(
    parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = lfu_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lfu_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lfu_pkg::CAP_BITS-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic [KEY_BITS-1:0]           lookup_key,
    input  logic [VALUE_BITS-1:0]         write_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic [VALUE_BITS-1:0]         read_value,
    output logic                          evicted,
    output logic [KEY_BITS-1:0]           evicted_key
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int HW = $clog2(ENTRIES + 1);
    localparam int CW = (HW > lfu_pkg::CAP_BITS) ? HW : lfu_pkg::CAP_BITS;
    localparam logic [CW-1:0] ENTRIES_C = CW'(ENTRIES);

    lfu_pkg::state_t state_reg, state_next;

    logic [lfu_pkg::CAP_BITS-1:0]   cap_reg;
    logic                           op_reg;
    logic [KEY_BITS-1:0]            key_reg;
    logic [VALUE_BITS-1:0]          wval_reg;
    logic [lfu_pkg::STAMP_BITS-1:0] stamp_reg;
    logic                           start_reg;

    logic                           out_valid_reg;
    logic                           hit_reg;
    logic [VALUE_BITS-1:0]          rval_reg;
    logic                           evicted_reg;
    logic [KEY_BITS-1:0]            ekey_reg;

    logic accept;
    logic commit;

    // token chain, element i feeds cell i
    logic                           t_active    [ENTRIES+1];
    logic                           t_found     [ENTRIES+1];
    logic [IW-1:0]                  t_found_idx [ENTRIES+1];
    logic [VALUE_BITS-1:0]          t_found_val [ENTRIES+1];
    logic [HW-1:0]                  t_held      [ENTRIES+1];
    logic                           t_vic_valid [ENTRIES+1];
    logic [IW-1:0]                  t_vic_idx   [ENTRIES+1];
    logic [COUNT_BITS-1:0]          t_vic_count [ENTRIES+1];
    logic [lfu_pkg::STAMP_BITS-1:0] t_vic_age   [ENTRIES+1];
    logic [KEY_BITS-1:0]            t_vic_key   [ENTRIES+1];
    logic                           t_free      [ENTRIES+1];
    logic [IW-1:0]                  t_free_idx  [ENTRIES+1];
    logic [ENTRIES-1:0]             active_vec;

    lfu_pkg::cmd_t   cmd;
    logic [IW-1:0]   insert_idx;
    logic [CW-1:0]   cap_eff;
    logic            cache_on;
    logic            full;
    logic            found_f;
    logic            evict_do;
    logic            insert_do;

    // start the token in the cycle after the beat so cell 0 sees the captured key
    assign t_active[0]    = start_reg;
    assign t_found[0]     = 1'b0;
    assign t_found_idx[0] = '0;
    assign t_found_val[0] = '0;
    assign t_held[0]      = '0;
    assign t_vic_valid[0] = 1'b0;
    assign t_vic_idx[0]   = '0;
    assign t_vic_count[0] = '0;
    assign t_vic_age[0]   = '0;
    assign t_vic_key[0]   = '0;
    assign t_free[0]      = 1'b0;
    assign t_free_idx[0]  = '0;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            assign active_vec[g] = t_active[g+1];
            lfu_cell #(
                .INDEX      (g),
                .ENTRIES    (ENTRIES),
                .KEY_BITS   (KEY_BITS),
                .VALUE_BITS (VALUE_BITS),
                .COUNT_BITS (COUNT_BITS),
                .IW         (IW),
                .HW         (HW)
            ) u_cell (
                .clk             (clk),
                .rst_n           (rst_n),
                .match_key       (key_reg),
                .stamp_now       (stamp_reg),
                .cmd             (cmd),
                .hit_idx         (t_found_idx[ENTRIES]),
                .evict_idx       (t_vic_idx[ENTRIES]),
                .insert_idx      (insert_idx),
                .new_value       (wval_reg),
                .in_active       (t_active[g]),
                .in_found        (t_found[g]),
                .in_found_idx    (t_found_idx[g]),
                .in_found_value  (t_found_val[g]),
                .in_held         (t_held[g]),
                .in_vic_valid    (t_vic_valid[g]),
                .in_vic_idx      (t_vic_idx[g]),
                .in_vic_count    (t_vic_count[g]),
                .in_vic_age      (t_vic_age[g]),
                .in_vic_key      (t_vic_key[g]),
                .in_free_found   (t_free[g]),
                .in_free_idx     (t_free_idx[g]),
                .out_active      (t_active[g+1]),
                .out_found       (t_found[g+1]),
                .out_found_idx   (t_found_idx[g+1]),
                .out_found_value (t_found_val[g+1]),
                .out_held        (t_held[g+1]),
                .out_vic_valid   (t_vic_valid[g+1]),
                .out_vic_idx     (t_vic_idx[g+1]),
                .out_vic_count   (t_vic_count[g+1]),
                .out_vic_age     (t_vic_age[g+1]),
                .out_vic_key     (t_vic_key[g+1]),
                .out_free_found  (t_free[g+1]),
                .out_free_idx    (t_free_idx[g+1])
            );
        end
    endgenerate

    // decision from the token that left the last cell
    always_comb
    begin
        cap_eff   = (CW'(cap_reg) > ENTRIES_C) ? ENTRIES_C : CW'(cap_reg);
        cache_on  = (cap_eff != '0);
        found_f   = cache_on && t_found[ENTRIES];
        full      = (CW'(t_held[ENTRIES]) >= cap_eff);
        insert_do = cache_on && !t_found[ENTRIES] && (op_reg == lfu_pkg::OP_SET);
        evict_do  = insert_do && full && t_vic_valid[ENTRIES];
        if (evict_do && !(t_free[ENTRIES] && (t_free_idx[ENTRIES] < t_vic_idx[ENTRIES])))
            insert_idx = t_vic_idx[ENTRIES];
        else
            insert_idx = t_free_idx[ENTRIES];
        cmd.touch     = commit && found_f;
        cmd.write_val = commit && found_f && (op_reg == lfu_pkg::OP_SET);
        cmd.evict     = commit && evict_do;
        cmd.insert    = commit && insert_do;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lfu_pkg::ST_IDLE: if (accept) state_next = lfu_pkg::ST_SCAN;
            lfu_pkg::ST_SCAN: if (t_active[ENTRIES]) state_next = lfu_pkg::ST_DONE;
            lfu_pkg::ST_DONE: if (commit) state_next = lfu_pkg::ST_IDLE;
            default:          state_next = lfu_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_stall  = 1'b1;
        cfg_ready = 1'b0;
        commit    = 1'b0;
        unique case (state_reg)
            lfu_pkg::ST_IDLE:
            begin
                in_stall  = 1'b0;
                cfg_ready = 1'b1;
            end
            lfu_pkg::ST_SCAN: ;
            lfu_pkg::ST_DONE: commit = !out_valid_reg || !out_stall;
            default: ;
        endcase
    end

    assign accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfu_pkg::ST_IDLE;
            cap_reg       <= lfu_pkg::CAP_RESET;
            stamp_reg     <= '0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= accept;
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
            if (cmd.touch || cmd.insert)
                stamp_reg <= stamp_reg + 1'b1;
            if (commit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= operation;
            key_reg  <= lookup_key;
            wval_reg <= write_value;
        end
        if (commit)
        begin
            hit_reg     <= found_f;
            rval_reg    <= (found_f && (op_reg == lfu_pkg::OP_GET)) ?
                           t_found_val[ENTRIES] : '0;
            evicted_reg <= evict_do;
            ekey_reg    <= evict_do ? t_vic_key[ENTRIES] : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign read_value  = rval_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = ekey_reg;

`ifndef SYNTHESIS
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(active_vec))
        else $error("more than one search token in the cell row");

    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == lfu_pkg::ST_SCAN))
        else $error("accepted beat did not start a scan");

    a_hit_no_insert: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.touch && (cmd.insert || cmd.evict)))
        else $error("hit and insert issued together");

    a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid)
        else $error("update without a result beat");
`endif

endmodule

@@ src/lfu_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cell
// One cache entry plus one stage of the search token that walks the row.
// ----------------------------------------------------------------------------
module lfu_cell #(
    parameter int INDEX      = 0,
    parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = lfu_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lfu_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF,
    parameter int IW         = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    parameter int HW         = $clog2(ENTRIES + 1)
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // broadcast
    input  logic [KEY_BITS-1:0]           match_key,
    input  logic [lfu_pkg::STAMP_BITS-1:0] stamp_now,
    input  lfu_pkg::cmd_t                 cmd,
    input  logic [IW-1:0]                 hit_idx,
    input  logic [IW-1:0]                 evict_idx,
    input  logic [IW-1:0]                 insert_idx,
    input  logic [VALUE_BITS-1:0]         new_value,
    // token from the previous cell
    input  logic                          in_active,
    input  logic                          in_found,
    input  logic [IW-1:0]                 in_found_idx,
    input  logic [VALUE_BITS-1:0]         in_found_value,
    input  logic [HW-1:0]                 in_held,
    input  logic                          in_vic_valid,
    input  logic [IW-1:0]                 in_vic_idx,
    input  logic [COUNT_BITS-1:0]         in_vic_count,
    input  logic [lfu_pkg::STAMP_BITS-1:0] in_vic_age,
    input  logic [KEY_BITS-1:0]           in_vic_key,
    input  logic                          in_free_found,
    input  logic [IW-1:0]                 in_free_idx,
    // token to the next cell
    output logic                          out_active,
    output logic                          out_found,
    output logic [IW-1:0]                 out_found_idx,
    output logic [VALUE_BITS-1:0]         out_found_value,
    output logic [HW-1:0]                 out_held,
    output logic                          out_vic_valid,
    output logic [IW-1:0]                 out_vic_idx,
    output logic [COUNT_BITS-1:0]         out_vic_count,
    output logic [lfu_pkg::STAMP_BITS-1:0] out_vic_age,
    output logic [KEY_BITS-1:0]           out_vic_key,
    output logic                          out_free_found,
    output logic [IW-1:0]                 out_free_idx
);

    localparam logic [IW-1:0]         MY_IDX    = IW'(INDEX);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic                           valid_reg;
    logic [KEY_BITS-1:0]            key_reg;
    logic [VALUE_BITS-1:0]          value_reg;
    logic [COUNT_BITS-1:0]          count_reg;
    logic [lfu_pkg::STAMP_BITS-1:0] stamp_reg;

    logic                           active_reg;
    logic                           found_reg;
    logic [IW-1:0]                  found_idx_reg;
    logic [VALUE_BITS-1:0]          found_value_reg;
    logic [HW-1:0]                  held_reg;
    logic                           vic_valid_reg;
    logic [IW-1:0]                  vic_idx_reg;
    logic [COUNT_BITS-1:0]          vic_count_reg;
    logic [lfu_pkg::STAMP_BITS-1:0] vic_age_reg;
    logic [KEY_BITS-1:0]            vic_key_reg;
    logic                           free_found_reg;
    logic [IW-1:0]                  free_idx_reg;

    logic [lfu_pkg::STAMP_BITS-1:0] age;
    logic                           is_match;
    logic                           is_victim;

    assign age       = stamp_now - stamp_reg;
    assign is_match  = valid_reg && !in_found && (key_reg == match_key);
    assign is_victim = valid_reg && (!in_vic_valid || (count_reg < in_vic_count) ||
                       ((count_reg == in_vic_count) && (age > in_vic_age)));

    // entry storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.touch && (hit_idx == MY_IDX))
            begin
                if (count_reg != COUNT_MAX)
                    count_reg <= count_reg + 1'b1;
            end
            if (cmd.evict && (evict_idx == MY_IDX))
            begin
                valid_reg <= 1'b0;
                count_reg <= '0;
            end
            if (cmd.insert && (insert_idx == MY_IDX))
            begin
                valid_reg <= 1'b1;
                count_reg <= COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.touch && (hit_idx == MY_IDX))
        begin
            stamp_reg <= stamp_now;
            if (cmd.write_val)
                value_reg <= new_value;
        end
        if (cmd.insert && (insert_idx == MY_IDX))
        begin
            key_reg   <= match_key;
            value_reg <= new_value;
            stamp_reg <= stamp_now;
        end
    end

    // token stage: advance one cell per cycle, hold otherwise
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= 1'b0;
        else
            active_reg <= in_active;
    end

    always_ff @(posedge clk)
    begin
        if (in_active)
        begin
            found_reg       <= in_found || is_match;
            found_idx_reg   <= is_match ? MY_IDX : in_found_idx;
            found_value_reg <= is_match ? value_reg : in_found_value;
            held_reg        <= in_held + HW'(valid_reg);
            vic_valid_reg   <= in_vic_valid || valid_reg;
            vic_idx_reg     <= is_victim ? MY_IDX : in_vic_idx;
            vic_count_reg   <= is_victim ? count_reg : in_vic_count;
            vic_age_reg     <= is_victim ? age : in_vic_age;
            vic_key_reg     <= is_victim ? key_reg : in_vic_key;
            free_found_reg  <= in_free_found || !valid_reg;
            free_idx_reg    <= (!in_free_found && !valid_reg) ? MY_IDX : in_free_idx;
        end
    end

    assign out_active      = active_reg;
    assign out_found       = found_reg;
    assign out_found_idx   = found_idx_reg;
    assign out_found_value = found_value_reg;
    assign out_held        = held_reg;
    assign out_vic_valid   = vic_valid_reg;
    assign out_vic_idx     = vic_idx_reg;
    assign out_vic_count   = vic_count_reg;
    assign out_vic_age     = vic_age_reg;
    assign out_vic_key     = vic_key_reg;
    assign out_free_found  = free_found_reg;
    assign out_free_idx    = free_idx_reg;

endmodule
